// File: hdl/odlr_pkg.sv
// Package: shared constants and helper functions for the optical density block.
`timescale 1ns / 1ps
`default_nettype none
package odlr_pkg;

  localparam int READING_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam int DENS_W = 23;
  localparam int DP_W = 3;
  localparam int POW_W = 20;
  localparam int QB = 27;

  localparam logic [DP_W-1:0] DP_RESET = 3'd3;
  localparam logic [DP_W-1:0] DP_MAX = 3'd6;

  localparam logic [QB-1:0] Q_MAX = 27'd100000000;
  localparam logic [QB-1:0] Q_LIMIT = 27'd100000001;
  localparam logic [13:0] RATIO_SCALE = 14'd10000;
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
  localparam logic [8:0] BIAS_LSB = 9'd256;
  localparam logic [DENS_W-1:0] OUT_LIMIT = 23'd4000000;

  function automatic logic [POW_W-1:0] pow10(input logic [DP_W-1:0] p);
    logic [POW_W-1:0] r;
    unique case (p)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] top_bit(input logic [QB-1:0] q);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < QB; i++) begin
      if (q[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// File: hdl/odlr_ifs.sv
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface odlr_item_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample_reading;
  logic [W-1:0] base_reading;
  logic [W-1:0] blank_reading;
  modport source (output valid, sample_reading, base_reading, blank_reading, input ready);
  modport sink (input valid, sample_reading, base_reading, blank_reading, output ready);
endinterface

interface odlr_result_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] density_scaled;
  logic               forced_zero;
  logic               ratio_clamped;
  modport source (output valid, density_scaled, forced_zero, ratio_clamped, input ready);
  modport sink (input valid, density_scaled, forced_zero, ratio_clamped, output ready);
endinterface

interface odlr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] decimal_places;
  modport source (output valid, decimal_places, input ready);
  modport sink (input valid, decimal_places, output ready);
endinterface
`default_nettype wire

// File: hdl/odlr_queue.sv
// Small FIFO between the classifying front and the compute back.
`timescale 1ns / 1ps
`default_nettype none
module odlr_queue #(
  parameter int W = 49,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && not_empty) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/odlr_front.sv
// Front: accept readings, form differences, flag the forced-zero case.
`timescale 1ns / 1ps
`default_nettype none
module odlr_front #(
  parameter int READING_BITS = 24
) (
  odlr_item_if.sink                 items,
  input  wire logic                 queue_full,
  output logic                      push,
  output logic [2*READING_BITS:0]   entry
);
  localparam int R = READING_BITS;

  logic         fz;
  logic [R-1:0] smp;
  logic [R-1:0] bas;
  logic [R-1:0] blk;
  logic [R-1:0] range_d;
  logic [R-1:0] val_d;

  // Keep only the low READING_BITS bits of each reading.
  assign smp = R'(items.sample_reading);
  assign bas = R'(items.base_reading);
  assign blk = R'(items.blank_reading);

  // A difference below one means the later reading does not exceed the base.
  assign fz      = (blk <= bas) || (smp <= bas);
  assign range_d = blk - bas;
  assign val_d   = smp - bas;

  assign items.ready = !queue_full;
  assign push        = items.valid && !queue_full;
  assign entry       = {fz, range_d, val_d};
endmodule
`default_nettype wire

// File: hdl/odlr_back.sv
// Back: divide, log2 by repeated squaring, scale to log10 and drive results.
`timescale 1ns / 1ps
`default_nettype none
module odlr_back #(
  parameter int READING_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [2:0]              decimal_places,
  input  wire logic                    q_valid,
  input  wire logic [2*READING_BITS:0] q_entry,
  output logic                         q_pop,
  odlr_result_if.source                results
);
  import odlr_pkg::*;

  localparam int R  = READING_BITS;
  localparam int NB = R + 14;
  localparam int DW = R + QB;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MULN  = 12'b000000000010,
    S_OVF   = 12'b000000000100,
    S_DIV   = 12'b000000001000,
    S_NORM  = 12'b000000010000,
    S_SQ    = 12'b000000100000,
    S_HI    = 12'b000001000000,
    S_LO    = 12'b000010000000,
    S_SUM   = 12'b000100000000,
    S_SIGN  = 12'b001000000000,
    S_SCALE = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t        state;
  logic [R-1:0]  rng;
  logic [R-1:0]  vl;
  logic [NB-1:0] num;
  logic [DW-1:0] lim;
  logic [NB-1:0] rem;
  logic [DW-1:0] dsh;
  logic [QB-1:0] quo;
  logic [4:0]    cnt;
  logic          fz;
  logic          clamp;
  logic [4:0]    e;
  logic [31:0]   m;
  logic [31:0]   frac;
  logic [52:0]   phi;
  logic [31:0]   plo;
  logic [37:0]   l10;
  logic          neg;
  logic [37:0]   mag;
  logic [57:0]   prod_s;

  logic          out_valid;
  logic [DENS_W-1:0] out_dens;
  logic          out_fz;
  logic          out_clamp;

  logic [QB-1:0] qv;
  logic [63:0]   sq;
  logic [32:0]   sq_t;
  logic [36:0]   l2;
  logic [47:0]   lo_prod;
  logic [53:0]   l10_sum;
  logic [37:0]   four;
  logic [DP_W-1:0] p;
  logic [25:0]   t_raw;
  logic [DENS_W-1:0] t_sat;
  logic          fin_go;

  assign qv      = (quo == '0) ? QB'(1) : quo;
  assign sq      = 64'(m) * 64'(m);
  assign sq_t    = sq[63:31];
  assign l2      = {e, frac};
  assign lo_prod = 48'(l2[15:0]) * 48'(LOG10_2_Q32);
  assign l10_sum = 54'(phi) + 54'(plo);
  assign four    = 38'd4 << 32;
  assign p       = (decimal_places > DP_MAX) ? DP_MAX : decimal_places;
  assign t_raw   = prod_s[57:32];
  assign t_sat   = (t_raw > 26'(OUT_LIMIT)) ? OUT_LIMIT : t_raw[DENS_W-1:0];
  assign fin_go  = (state == S_FIN) && (!out_valid || results.ready);
  assign q_pop   = (state == S_IDLE) && q_valid;

  assign results.valid          = out_valid;
  assign results.density_scaled = out_dens;
  assign results.forced_zero    = out_fz;
  assign results.ratio_clamped  = out_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (q_valid) state <= q_entry[2*R] ? S_FIN : S_MULN;
        S_MULN:  state <= S_OVF;
        S_OVF:   state <= (DW'(num) >= lim) ? S_NORM : S_DIV;
        S_DIV:   if (cnt == 5'(QB - 1)) state <= S_NORM;
        S_NORM:  state <= S_SQ;
        S_SQ:    if (cnt == 5'd31) state <= S_HI;
        S_HI:    state <= S_LO;
        S_LO:    state <= S_SUM;
        S_SUM:   state <= S_SIGN;
        S_SIGN:  state <= S_SCALE;
        S_SCALE: state <= S_FIN;
        S_FIN:   if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        fz     <= q_entry[2*R];
        rng    <= q_entry[2*R-1:R];
        vl     <= q_entry[R-1:0];
        clamp  <= 1'b0;
        neg    <= 1'b0;
        prod_s <= '0;
      end
      S_MULN: begin
        num <= NB'(rng) * NB'(RATIO_SCALE);
        lim <= DW'(vl) * DW'(Q_LIMIT);
      end
      S_OVF: begin
        // Quotient above the top of the range: clamp without dividing.
        if (DW'(num) >= lim) clamp <= 1'b1;
        rem <= num;
        dsh <= DW'(vl) << (QB - 1);
        quo <= (DW'(num) >= lim) ? Q_MAX : '0;
        cnt <= '0;
      end
      S_DIV: begin
        if (DW'(rem) >= dsh) begin
          rem <= rem - dsh[NB-1:0];
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          quo <= {quo[QB-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      S_NORM: begin
        if (quo == '0) clamp <= 1'b1;
        e    <= top_bit(qv);
        m    <= 32'(qv) << (5'd31 - top_bit(qv));
        frac <= '0;
        cnt  <= '0;
      end
      S_SQ: begin
        if (sq_t[32]) begin
          m    <= sq_t[32:1];
          frac <= {frac[30:0], 1'b1};
        end else begin
          m    <= sq_t[31:0];
          frac <= {frac[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      S_HI:  phi <= 53'(l2[36:16]) * 53'(LOG10_2_Q32);
      S_LO:  plo <= lo_prod[47:16];
      S_SUM: l10 <= l10_sum[53:16];
      S_SIGN: begin
        // Bias undoes the downward drift of the truncations.
        if (l10 >= four) begin
          neg <= 1'b0;
          mag <= l10 - four + 38'(BIAS_LSB);
        end else begin
          neg <= 1'b1;
          mag <= four - l10 + 38'(BIAS_LSB);
        end
      end
      S_SCALE: prod_s <= 58'(mag) * 58'(pow10(p));
      S_FIN: begin
        if (fin_go) begin
          out_dens  <= neg ? (DENS_W'(0) - t_sat) : t_sat;
          out_fz    <= fz;
          out_clamp <= clamp;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/optical_density_log_ratio_top.sv
// Top level: optical density as scaled log10 of blank over sample light.
//
//  channel  | dir | payload                                         | accepted when
//  ---------+-----+-------------------------------------------------+-------------------
//  cfg      | in  | decimal_places[2:0]                             | valid && ready
//  items    | in  | sample_reading, base_reading, blank_reading     | valid && ready
//  results  | out | density_scaled[22:0] s, forced_zero, ratio_clamped | valid && ready
//
// Compute: the back works on one transaction at a time. A forced-zero transaction
//   skips the compute states, a ratio clamped at the top skips the divide, and any
//   other runs the 27-step bit-serial divider and the 32 squarings of log2.
// The front takes one transaction a cycle into a 4-entry queue until it fills.
// Reset: rst is synchronous, active high; decimal_places resets to 3, queue empties.
// Stalls: a held result in the output register stalls only the back; the front
//   keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none
module optical_density_log_ratio_top #(
  parameter int READING_BITS = odlr_pkg::READING_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  odlr_cfg_if.sink      cfg,
  odlr_item_if.sink     items,
  odlr_result_if.source results
);
  import odlr_pkg::*;

  localparam int EW = 2 * READING_BITS + 1;

  logic [DP_W-1:0] decimal_places;
  logic            queue_full;
  logic            push;
  logic [EW-1:0]   entry;
  logic            pop;
  logic [EW-1:0]   pop_data;
  logic            not_empty;

  // Configuration is always taken; the source must write only while nothing is in flight (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_places <= DP_RESET;
    end else if (cfg.valid) begin
      decimal_places <= cfg.decimal_places;
    end
  end

  // Front: classify and push each transaction into the queue.
  odlr_front #(.READING_BITS(READING_BITS)) u_front (
    .items      (items),
    .queue_full (queue_full),
    .push       (push),
    .entry      (entry)
  );

  // Queue: decouple acceptance from the long compute in the back.
  odlr_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  // Back: divide, take the logarithm, scale and hold the result.
  odlr_back #(.READING_BITS(READING_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .decimal_places (decimal_places),
    .q_valid        (not_empty),
    .q_entry        (pop_data),
    .q_pop          (pop),
    .results        (results)
  );
endmodule
`default_nettype wire
